FILE: hw/rtl/lfr_pkg.sv
// ----------------------------------------------------------------------------
// Line/JSON framer package
// Shared byte codes, mode and status codes, defaults and the result word type.
// ----------------------------------------------------------------------------
package lfr_pkg;

  // Field widths fixed by the interface.
  localparam int BYTE_W   = 8;
  localparam int CODE_W   = 2;
  localparam int CFG_W    = 12;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // Defaults for the top-level parameters.
  localparam int DEPTH_WIDTH_DEF = 9;
  localparam int COUNT_WIDTH_DEF = 12;

  // Reset value of the pending limit register.
  localparam logic [CFG_W-1:0] MAX_PENDING_RESET = 12'd2048;

  // Register index carried in paddr[2].
  localparam logic REG_MAX_PENDING = 1'b0;

  // Byte codes.
  localparam logic [BYTE_W-1:0] BYTE_TAB       = 8'h09;
  localparam logic [BYTE_W-1:0] BYTE_LF        = 8'h0A;
  localparam logic [BYTE_W-1:0] BYTE_VT        = 8'h0B;
  localparam logic [BYTE_W-1:0] BYTE_FF        = 8'h0C;
  localparam logic [BYTE_W-1:0] BYTE_CR        = 8'h0D;
  localparam logic [BYTE_W-1:0] BYTE_SPACE     = 8'h20;
  localparam logic [BYTE_W-1:0] BYTE_QUOTE     = 8'h22;
  localparam logic [BYTE_W-1:0] BYTE_LBRACKET  = 8'h5B;
  localparam logic [BYTE_W-1:0] BYTE_BACKSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] BYTE_RBRACKET  = 8'h5D;
  localparam logic [BYTE_W-1:0] BYTE_LBRACE    = 8'h7B;
  localparam logic [BYTE_W-1:0] BYTE_RBRACE    = 8'h7D;

  typedef enum logic [CODE_W-1:0] {
    MODE_UNDECIDED = 2'd0,
    MODE_LINE      = 2'd1,
    MODE_JSON      = 2'd2
  } mode_t;

  typedef enum logic [CODE_W-1:0] {
    ST_PENDING   = 2'd0,
    ST_LINE_DONE = 2'd1,
    ST_JSON_DONE = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    status_t           status;
    mode_t             mode;
  } result_t;

endpackage

FILE: hw/rtl/line_or_json_message_framer.sv
// ----------------------------------------------------------------------------
// Line-or-JSON message framer
// Frames a received byte stream as newline-terminated lines or as balanced
// JSON objects and arrays, passing every kept byte through with a status.
// ----------------------------------------------------------------------------
//
//   channel  | handshake             | word
//   ---------+-----------------------+-------------------------------------
//   input    | in_valid / in_stall   | rx_byte
//   output   | out_valid / out_stall | data_byte, frame_status, frame_mode
//   config   | APB psel/penable      | max_pending at byte address 0
//
// The block takes one byte per cycle while in_stall is low. A byte waits in
// the input register until the result register is free, then its word loads
// there and leaves once out_stall is low. The framer state is updated at the
// edge the result register loads, so consecutive bytes see each other's effect.
// Carriage returns leave the input register without producing a word, and
// reset is synchronous and clears both register stages and the framer state.
// in_stall is high only while a byte other than a carriage return waits in
// the input register and the output side stalls a word in the result register.
//
module line_or_json_message_framer #(
  parameter int DEPTH_WIDTH = lfr_pkg::DEPTH_WIDTH_DEF,
  parameter int COUNT_WIDTH = lfr_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // Byte input channel.
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lfr_pkg::BYTE_W-1:0]   rx_byte,
  // Result output channel.
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lfr_pkg::BYTE_W-1:0]   data_byte,
  output logic [lfr_pkg::CODE_W-1:0]   frame_status,
  output logic [lfr_pkg::CODE_W-1:0]   frame_mode,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lfr_pkg::PADDR_W-1:0]  paddr,
  input  logic [lfr_pkg::PDATA_W-1:0]  pwdata,
  output logic [lfr_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import lfr_pkg::*;

  logic              in_full;
  logic [BYTE_W-1:0] in_data;
  logic              is_cr;
  logic              out_free;
  logic              advance;
  logic              step;
  logic [CFG_W-1:0]  max_pending;
  result_t           core_result;
  result_t           out_word;

  lfr_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_pending (max_pending)
  );

  lfr_core #(
    .DEPTH_WIDTH (DEPTH_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .byte_in     (in_data),
    .max_pending (max_pending),
    .result      (core_result)
  );

  // The result register can load when it is empty or its word leaves now.
  assign out_free = !out_valid || !out_stall;
  // A carriage return is dropped without needing room at the output.
  assign is_cr    = (in_data == BYTE_CR);
  assign advance  = in_full && (is_cr || out_free);
  assign step     = advance && !is_cr;
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word <= core_result;
    end
  end

  assign data_byte    = out_word.data;
  assign frame_status = out_word.status;
  assign frame_mode   = out_word.mode;

  // An overflow is only possible before any mode has been chosen.
  a_overflow_undecided: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_status == ST_OVERFLOW) |-> (frame_mode == MODE_UNDECIDED))
    else $error("overflow reported outside undecided mode");

  // A line frame ends only on a newline seen in line mode.
  a_line_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_status == ST_LINE_DONE) |->
      (frame_mode == MODE_LINE && data_byte == BYTE_LF))
    else $error("line frame end on wrong byte or mode");

  // A JSON frame end is reported only in JSON mode.
  a_json_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_status == ST_JSON_DONE) |-> (frame_mode == MODE_JSON))
    else $error("json frame end outside json mode");

  // Carriage returns never reach the output.
  a_no_cr: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (data_byte != BYTE_CR))
    else $error("carriage return passed through");

  // The input side is held back only by a stalled, full result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_full && out_valid && out_stall && !is_cr))
    else $error("input stalled without a full output");

endmodule

FILE: hw/rtl/lfr_cfg.sv
// ----------------------------------------------------------------------------
// Line/JSON framer configuration registers
// APB-style register file holding the pending byte limit.
// ----------------------------------------------------------------------------
module lfr_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfr_pkg::PADDR_W-1:0] paddr,
  input  logic [lfr_pkg::PDATA_W-1:0] pwdata,
  output logic [lfr_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [lfr_pkg::CFG_W-1:0]   max_pending
);
  import lfr_pkg::*;

  logic wr_en;
  logic sel_max;

  assign sel_max = (paddr[2] == REG_MAX_PENDING);
  assign wr_en   = psel && penable && pwrite && sel_max;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_pending <= MAX_PENDING_RESET;
    end else if (wr_en) begin
      max_pending <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_max) begin
      prdata = PDATA_W'(max_pending);
    end
  end

endmodule

FILE: hw/rtl/lfr_core.sv
// ----------------------------------------------------------------------------
// Line/JSON framer core
// Framer state and the single-pass next-state and result logic for one byte.
// ----------------------------------------------------------------------------
module lfr_core #(
  parameter int DEPTH_WIDTH = lfr_pkg::DEPTH_WIDTH_DEF,
  parameter int COUNT_WIDTH = lfr_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [lfr_pkg::BYTE_W-1:0] byte_in,
  input  logic [lfr_pkg::CFG_W-1:0]  max_pending,
  output lfr_pkg::result_t           result
);
  import lfr_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam logic signed [DEPTH_WIDTH-1:0] DEPTH_MAX = {1'b0, {(DEPTH_WIDTH-1){1'b1}}};
  localparam logic signed [DEPTH_WIDTH-1:0] DEPTH_MIN = {1'b1, {(DEPTH_WIDTH-1){1'b0}}};
  localparam logic signed [DEPTH_WIDTH-1:0] DEPTH_ONE = DEPTH_WIDTH'(1);

  mode_t                          mode, mode_next, mode_eff;
  logic signed [DEPTH_WIDTH-1:0]  brace_level, brace_next, brace_upd;
  logic signed [DEPTH_WIDTH-1:0]  bracket_level, bracket_next, bracket_upd;
  logic                           inside_string, inside_next, inside_upd;
  logic [BYTE_W-1:0]              previous_byte, previous_next, previous_upd;
  logic [COUNT_WIDTH-1:0]         pending_count, pending_next, pending_upd;
  logic                           is_white;
  logic                           is_opener;
  status_t                        status;

  assign is_white = (byte_in == BYTE_SPACE) || (byte_in == BYTE_TAB) ||
                    (byte_in == BYTE_LF) || (byte_in == BYTE_VT) ||
                    (byte_in == BYTE_FF) || (byte_in == BYTE_CR);
  assign is_opener = (byte_in == BYTE_LBRACE) || (byte_in == BYTE_LBRACKET);

  always_comb begin
    pending_upd  = (&pending_count) ? pending_count
                                    : pending_count + COUNT_WIDTH'(1);
    brace_upd    = brace_level;
    bracket_upd  = bracket_level;
    inside_upd   = inside_string;
    previous_upd = previous_byte;
    status       = ST_PENDING;

    mode_eff = mode;
    if (mode == MODE_UNDECIDED && !is_white) begin
      mode_eff = is_opener ? MODE_JSON : MODE_LINE;
    end

    case (mode_eff)
      MODE_LINE: begin
        if (byte_in == BYTE_LF) begin
          status = ST_LINE_DONE;
        end
      end
      MODE_JSON: begin
        // A quote after a backslash is escaped and leaves the string flag alone.
        if (byte_in == BYTE_QUOTE && previous_byte != BYTE_BACKSLASH) begin
          inside_upd = !inside_string;
        end
        if (!inside_upd) begin
          if (byte_in == BYTE_LBRACE && brace_level != DEPTH_MAX) begin
            brace_upd = brace_level + DEPTH_ONE;
          end else if (byte_in == BYTE_RBRACE && brace_level != DEPTH_MIN) begin
            brace_upd = brace_level - DEPTH_ONE;
          end else if (byte_in == BYTE_LBRACKET && bracket_level != DEPTH_MAX) begin
            bracket_upd = bracket_level + DEPTH_ONE;
          end else if (byte_in == BYTE_RBRACKET && bracket_level != DEPTH_MIN) begin
            bracket_upd = bracket_level - DEPTH_ONE;
          end
        end
        previous_upd = byte_in;
        if (!inside_upd && brace_upd == '0 && bracket_upd == '0) begin
          status = ST_JSON_DONE;
        end
      end
      default: begin
        if (CMP_W'(pending_upd) > CMP_W'(max_pending)) begin
          status = ST_OVERFLOW;
        end
      end
    endcase

    // Any frame end or overflow returns the framer to its idle state.
    if (status != ST_PENDING) begin
      mode_next     = MODE_UNDECIDED;
      brace_next    = '0;
      bracket_next  = '0;
      inside_next   = 1'b0;
      previous_next = '0;
      pending_next  = '0;
    end else begin
      mode_next     = mode_eff;
      brace_next    = brace_upd;
      bracket_next  = bracket_upd;
      inside_next   = inside_upd;
      previous_next = previous_upd;
      pending_next  = pending_upd;
    end

    result.data   = byte_in;
    result.status = status;
    result.mode   = mode_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_UNDECIDED;
      brace_level   <= '0;
      bracket_level <= '0;
      inside_string <= 1'b0;
      previous_byte <= '0;
      pending_count <= '0;
    end else if (step) begin
      mode          <= mode_next;
      brace_level   <= brace_next;
      bracket_level <= bracket_next;
      inside_string <= inside_next;
      previous_byte <= previous_next;
      pending_count <= pending_next;
    end
  end

endmodule
